FILE: sv/pcs_pkg.sv
package pcs_pkg;

    localparam int DIST_W = 34;
    localparam int RAD_W  = 12;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 12'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_MAXP,
        ST_SCAN
    } st_t;

    typedef enum logic {
        TOK_POINT,
        TOK_MAX
    } tok_mode_t;

    // flag: point joined a group (point pass) / a best group was found (max pass)
    typedef struct packed {
        logic      valid;
        tok_mode_t mode;
        logic      flag;
    } tok_ctl_t;

    function automatic logic [DIST_W-1:0] sq_dist(
        input logic [15:0] ax,
        input logic [15:0] ay,
        input logic [15:0] bx,
        input logic [15:0] by
    );
        logic [15:0] dx;
        logic [15:0] dy;
        logic [31:0] dx2;
        logic [31:0] dy2;
        dx  = (ax > bx) ? (ax - bx) : (bx - ax);
        dy  = (ay > by) ? (ay - by) : (by - ay);
        dx2 = dx * dx;
        dy2 = dy * dy;
        return DIST_W'(dx2) + DIST_W'(dy2);
    endfunction

endpackage

FILE: sv/pcs_cell.sv
module pcs_cell
    import pcs_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int COORD_BITS = 12,
    parameter int GW         = 6,
    parameter int SW         = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DIST_W-1:0]     r2,
    input  logic [GW:0]           group_count,
    input  logic                  create_en,
    input  logic [GW-1:0]         create_idx,
    input  logic [COORD_BITS-1:0] create_x,
    input  logic [COORD_BITS-1:0] create_y,
    input  tok_ctl_t              in_ctl,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic [SW-1:0]         in_bsize,
    input  logic [GW-1:0]         in_bidx,
    output tok_ctl_t              out_ctl,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic [SW-1:0]         out_bsize,
    output logic [GW-1:0]         out_bidx,
    output logic                  hit
);

    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [SW-1:0]         size_reg;
    logic                  live;
    logic                  near;
    logic                  take;
    logic [COORD_BITS:0]   sum_x;
    logic [COORD_BITS:0]   sum_y;
    logic [GW:0]           idx_w;

    assign idx_w = (GW+1)'(IDX);
    assign live  = idx_w < group_count;
    assign near  = sq_dist(16'(cx_reg), 16'(cy_reg), 16'(in_x), 16'(in_y)) <= r2;
    assign hit   = in_ctl.valid && (in_ctl.mode == TOK_POINT) && live && near;
    // strict compare keeps the earliest group on a tie
    assign take  = in_ctl.valid && (in_ctl.mode == TOK_MAX) && live
                   && (!in_ctl.flag || (size_reg > in_bsize));
    assign sum_x = {1'b0, cx_reg} + {1'b0, in_x};
    assign sum_y = {1'b0, cy_reg} + {1'b0, in_y};

    always_ff @(posedge clk)
    begin
        if (create_en && (create_idx == idx_w[GW-1:0]))
        begin
            cx_reg   <= create_x;
            cy_reg   <= create_y;
            size_reg <= SW'(1);
        end
        else if (hit)
        begin
            cx_reg   <= sum_x[COORD_BITS:1];
            cy_reg   <= sum_y[COORD_BITS:1];
            size_reg <= size_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl <= '0;
        end
        else
        begin
            out_ctl <= '{valid: in_ctl.valid, mode: in_ctl.mode,
                         flag: in_ctl.flag | hit | take};
        end
    end

    // in the max pass the token carries the best centre in its x/y slots
    always_ff @(posedge clk)
    begin
        out_x     <= take ? cx_reg : in_x;
        out_y     <= take ? cy_reg : in_y;
        out_bsize <= take ? size_reg : in_bsize;
        out_bidx  <= take ? idx_w[GW-1:0] : in_bidx;
    end

endmodule

FILE: sv/point_cluster_select.sv
// Channel   Signals                                         Direction  Transfer
// command   start, busy, has_point, point_x, point_y,       in         start && !busy
//           last_point
// result    done, found, best_x, best_y, overflowed         out        done (one cycle)
// config    cfg_we, cfg_wdata                               in         cfg_we
//
// A point item sends a token along the chain of group cells, one cell per
// clock. A last item adds a second walk that picks the largest group, then,
// if a group exists, a scan of the point store at one entry per clock
// through a 3-stage read/distance/compare pipeline.
// An item with neither point nor last mark finishes in its accept cycle.
// Reset clears counters and control only; stores need no clearing pass.
// The result receiver cannot stall; done is a one-cycle strobe.
module point_cluster_select
    import pcs_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_GROUPS = 64,
    parameter int COORD_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        has_point,
    input  logic [11:0] point_x,
    input  logic [11:0] point_y,
    input  logic        last_point,
    output logic        done,
    output logic        found,
    output logic [11:0] best_x,
    output logic [11:0] best_y,
    output logic        overflowed,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int GW = $clog2(MAX_GROUPS);
    localparam int SW = PW + 1;
    localparam int CB = COORD_BITS;

    st_t state_reg, state_next;

    logic [RAD_W-1:0]   radius_reg;
    logic [DIST_W-1:0]  r2_reg;
    logic [2*RAD_W-1:0] rad_sq;

    logic [PW:0]   pcount_reg;
    logic [GW:0]   gcount_reg;
    logic          ovf_reg;
    logic          last_reg;
    logic [PW-1:0] pidx_reg;
    logic [CB-1:0] px_reg;
    logic [CB-1:0] py_reg;
    logic [MAX_GROUPS-1:0] memv_reg;

    // launch register feeding cell 0
    tok_ctl_t      tok_ctl_reg;
    logic [CB-1:0] tok_x_reg;
    logic [CB-1:0] tok_y_reg;

    // chain wiring
    tok_ctl_t      c_ctl   [0:MAX_GROUPS];
    logic [CB-1:0] c_x     [0:MAX_GROUPS];
    logic [CB-1:0] c_y     [0:MAX_GROUPS];
    logic [SW-1:0] c_bsize [0:MAX_GROUPS];
    logic [GW-1:0] c_bidx  [0:MAX_GROUPS];
    logic [MAX_GROUPS-1:0] hit_vec;

    logic create_en;
    logic accept;
    logic full;
    logic chain_done;
    logic [15:0] in_x16;
    logic [15:0] in_y16;

    // stores
    logic [CB-1:0]         sx_mem [0:MAX_POINTS-1];
    logic [CB-1:0]         sy_mem [0:MAX_POINTS-1];
    logic [MAX_GROUPS-1:0] sm_mem [0:MAX_POINTS-1];

    // scan pipeline
    logic [PW:0]           saddr_reg;
    logic                  s1v_reg;
    logic [CB-1:0]         rdx_reg;
    logic [CB-1:0]         rdy_reg;
    logic [MAX_GROUPS-1:0] rdm_reg;
    logic                  s2v_reg;
    logic [DIST_W-1:0]     s2d_reg;
    logic [CB-1:0]         s2x_reg;
    logic [CB-1:0]         s2y_reg;
    logic                  bhave_reg;
    logic [DIST_W-1:0]     bd_reg;
    logic [CB-1:0]         bx_reg;
    logic [CB-1:0]         by_reg;
    logic [GW-1:0]         bidx_reg;
    logic [CB-1:0]         bcx_reg;
    logic [CB-1:0]         bcy_reg;
    logic                  issue;
    logic                  scan_end;

    // result registers
    logic          done_reg;
    logic          found_reg;
    logic [CB-1:0] ox_reg;
    logic [CB-1:0] oy_reg;
    logic          ovo_reg;
    logic [15:0]   ox16;
    logic [15:0]   oy16;

    assign busy       = state_reg != ST_IDLE;
    assign accept     = start && !busy;
    assign full       = pcount_reg >= (PW+1)'(MAX_POINTS);
    assign chain_done = c_ctl[MAX_GROUPS].valid;
    assign in_x16     = 16'(point_x);
    assign in_y16     = 16'(point_y);
    assign rad_sq     = radius_reg * radius_reg;
    assign create_en  = (state_reg == ST_PASS) && chain_done && !c_ctl[MAX_GROUPS].flag
                        && (gcount_reg < (GW+1)'(MAX_GROUPS));
    assign issue      = (state_reg == ST_SCAN) && (saddr_reg < pcount_reg);
    assign scan_end   = (state_reg == ST_SCAN) && !issue && !s1v_reg && !s2v_reg;

    assign c_ctl[0]   = tok_ctl_reg;
    assign c_x[0]     = tok_x_reg;
    assign c_y[0]     = tok_y_reg;
    assign c_bsize[0] = '0;
    assign c_bidx[0]  = '0;

    for (genvar i = 0; i < MAX_GROUPS; i++)
    begin : g_cell
        pcs_cell #(
            .IDX        (i),
            .COORD_BITS (CB),
            .GW         (GW),
            .SW         (SW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .r2          (r2_reg),
            .group_count (gcount_reg),
            .create_en   (create_en),
            .create_idx  (gcount_reg[GW-1:0]),
            .create_x    (px_reg),
            .create_y    (py_reg),
            .in_ctl      (c_ctl[i]),
            .in_x        (c_x[i]),
            .in_y        (c_y[i]),
            .in_bsize    (c_bsize[i]),
            .in_bidx     (c_bidx[i]),
            .out_ctl     (c_ctl[i+1]),
            .out_x       (c_x[i+1]),
            .out_y       (c_y[i+1]),
            .out_bsize   (c_bsize[i+1]),
            .out_bidx    (c_bidx[i+1]),
            .hit         (hit_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_point && !full)
                        state_next = ST_PASS;
                    else if (last_point)
                        state_next = ST_MAXP;
                end
            end
            ST_PASS:
            begin
                if (chain_done)
                    state_next = last_reg ? ST_MAXP : ST_IDLE;
            end
            ST_MAXP:
            begin
                if (chain_done)
                    state_next = c_ctl[MAX_GROUPS].flag ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // config register and squared radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            r2_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                radius_reg <= cfg_wdata;
            r2_reg <= DIST_W'(rad_sq);
        end
    end

    // control: counters, flags, token launch, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg  <= '0;
            gcount_reg  <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            tok_ctl_reg <= '0;
            done_reg    <= 1'b0;
            saddr_reg   <= '0;
            s1v_reg     <= 1'b0;
            s2v_reg     <= 1'b0;
            bhave_reg   <= 1'b0;
        end
        else
        begin
            // result strobe: empty set at the end of the max walk, or end of scan
            done_reg <= ((state_reg == ST_MAXP) && chain_done && !c_ctl[MAX_GROUPS].flag)
                        || scan_end;
            s1v_reg  <= issue;
            s2v_reg  <= s1v_reg && rdm_reg[bidx_reg];
            if (issue)
                saddr_reg <= saddr_reg + (PW+1)'(1);

            // token launch: point walk on a stored point, max walk on a close
            if (accept && has_point && !full)
                tok_ctl_reg <= '{valid: 1'b1, mode: TOK_POINT, flag: 1'b0};
            else if ((accept && last_point)
                     || ((state_reg == ST_PASS) && chain_done && last_reg))
                tok_ctl_reg <= '{valid: 1'b1, mode: TOK_MAX, flag: 1'b0};
            else
                tok_ctl_reg <= '0;

            if (accept)
            begin
                last_reg <= last_point;
                if (has_point && !full)
                begin
                    pcount_reg <= pcount_reg + (PW+1)'(1);
                end
                else
                begin
                    if (has_point)
                        ovf_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_PASS) && chain_done)
            begin
                if (create_en)
                    gcount_reg <= gcount_reg + (GW+1)'(1);
                else if (!c_ctl[MAX_GROUPS].flag)
                    ovf_reg <= 1'b1;
            end

            if ((state_reg == ST_MAXP) && chain_done)
            begin
                saddr_reg <= '0;
                bhave_reg <= 1'b0;
                if (!c_ctl[MAX_GROUPS].flag)
                begin
                    // empty set
                    pcount_reg <= '0;
                    gcount_reg <= '0;
                    ovf_reg    <= 1'b0;
                end
            end

            if (s2v_reg && (!bhave_reg || (s2d_reg < bd_reg)))
                bhave_reg <= 1'b1;

            if (scan_end)
            begin
                pcount_reg <= '0;
                gcount_reg <= '0;
                ovf_reg    <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= in_x16[CB-1:0];
            py_reg    <= in_y16[CB-1:0];
            tok_x_reg <= in_x16[CB-1:0];
            tok_y_reg <= in_y16[CB-1:0];
            pidx_reg  <= pcount_reg[PW-1:0];
            memv_reg  <= '0;
        end
        else if (state_reg == ST_PASS)
        begin
            memv_reg <= memv_reg | hit_vec;
        end

        if ((state_reg == ST_MAXP) && chain_done)
        begin
            bidx_reg <= c_bidx[MAX_GROUPS];
            bcx_reg  <= c_x[MAX_GROUPS];
            bcy_reg  <= c_y[MAX_GROUPS];
        end

        s2d_reg <= sq_dist(16'(bcx_reg), 16'(bcy_reg), 16'(rdx_reg), 16'(rdy_reg));
        s2x_reg <= rdx_reg;
        s2y_reg <= rdy_reg;

        if (s2v_reg && (!bhave_reg || (s2d_reg < bd_reg)))
        begin
            bd_reg <= s2d_reg;
            bx_reg <= s2x_reg;
            by_reg <= s2y_reg;
        end

        if ((state_reg == ST_MAXP) && chain_done && !c_ctl[MAX_GROUPS].flag)
        begin
            found_reg <= 1'b0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            ovo_reg   <= ovf_reg;
        end
        else if (scan_end)
        begin
            found_reg <= bhave_reg;
            ox_reg    <= bhave_reg ? bx_reg : '0;
            oy_reg    <= bhave_reg ? by_reg : '0;
            ovo_reg   <= ovf_reg;
        end
    end

    // point store: coordinates at accept, membership when the token leaves
    always_ff @(posedge clk)
    begin
        if (accept && has_point && !full)
        begin
            sx_mem[pcount_reg[PW-1:0]] <= in_x16[CB-1:0];
            sy_mem[pcount_reg[PW-1:0]] <= in_y16[CB-1:0];
        end
        if (issue)
        begin
            rdx_reg <= sx_mem[saddr_reg[PW-1:0]];
            rdy_reg <= sy_mem[saddr_reg[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_PASS) && chain_done)
            sm_mem[pidx_reg] <= memv_reg
                | (create_en ? (MAX_GROUPS'(1) << gcount_reg[GW-1:0]) : '0);
        if (issue)
            rdm_reg <= sm_mem[saddr_reg[PW-1:0]];
    end

    assign ox16       = 16'(ox_reg);
    assign oy16       = 16'(oy_reg);
    assign done       = done_reg;
    assign found      = found_reg;
    assign best_x     = ox16[11:0];
    assign best_y     = oy16[11:0];
    assign overflowed = ovo_reg;

    a_clear_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (pcount_reg == '0) && (gcount_reg == '0) && !ovf_reg)
        else $error("counters not cleared with result");

    a_group_cap: assert property (@(posedge clk) disable iff (!rst_n)
        gcount_reg <= (GW+1)'(MAX_GROUPS))
        else $error("group count beyond capacity");

    a_point_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= (PW+1)'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ctl_reg.valid |=> !tok_ctl_reg.valid)
        else $error("second token launched into busy chain");

endmodule
